/* hdl/pgi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgi_pkg
// Types, constants and saturation helpers shared by the gravity integrator.
// ----------------------------------------------------------------------------
package pgi_pkg;

    localparam int CFG_COUNT = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VZ  = 3'd6;

    localparam logic [31:0] RST_ATTR_X   = 32'd19660800;
    localparam logic [31:0] RST_ATTR_Y   = 32'd0;
    localparam logic [31:0] RST_ATTR_Z   = 32'd0;
    localparam logic [31:0] RST_STRENGTH = 32'd3276800;
    localparam logic [31:0] RST_START_VX = 32'd0;
    localparam logic [31:0] RST_START_VY = 32'd13107;
    localparam logic [31:0] RST_START_VZ = 32'd45875;

    // Radicand, root and remainder widths of the shared iterative unit.
    localparam int RAD_W  = 68;
    localparam int ROOT_W = 34;
    localparam int DIST_W = 34;
    localparam int REM_W  = 38;

    localparam int TIME_BITS = 16;

    typedef enum logic
    {
        ITER_DIV,
        ITER_SQRT
    } iter_mode_t;

    typedef struct packed
    {
        logic       start;
        iter_mode_t mode;
    } iter_cmd_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } iter_stat_t;

    typedef struct packed
    {
        logic [15:0] frame_time;
        logic        restart;
    } in_item_t;

    typedef struct packed
    {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               saturated;
    } out_item_t;

    function automatic logic sat_ovf(input logic [33:0] x);
        return !((x[33] == x[32]) && (x[32] == x[31]));
    endfunction

    function automatic logic [31:0] sat_val(input logic [33:0] x);
        logic [31:0] r;
        if (sat_ovf(x))
        begin
            r = x[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/pgi_iter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgi_iter
// Shared restoring unit: unsigned division or integer square root, one
// quotient or root bit per cycle through a single subtract and compare.
// ----------------------------------------------------------------------------
module pgi_iter
    import pgi_pkg::*;
#(
    parameter int NUM_W = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire iter_cmd_t         cmd,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [RAD_W-1:0]  rad,
    input  wire logic [DIST_W-1:0] den,
    output      iter_stat_t        stat,
    output      logic [NUM_W-1:0]  quo
);

    localparam int SRC_W = (NUM_W > RAD_W) ? NUM_W : RAD_W;
    localparam int CW    = $clog2(SRC_W + 1);

    logic [SRC_W-1:0]  src_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [SRC_W-1:0]  res_reg;
    logic [DIST_W-1:0] den_reg;
    logic [CW-1:0]     cnt_reg;
    iter_mode_t        mode_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rsh;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              ge;

    always_comb
    begin
        if (mode_reg == ITER_SQRT)
        begin
            rsh   = {rem_reg[REM_W-3:0], src_reg[SRC_W-1:SRC_W-2]};
            trial = {2'b00, res_reg[ROOT_W-1:0], 2'b01};
        end
        else
        begin
            rsh   = {rem_reg[REM_W-2:0], src_reg[SRC_W-1]};
            trial = {{(REM_W-DIST_W){1'b0}}, den_reg};
        end
        diff = {1'b0, rsh} - {1'b0, trial};
        ge   = !diff[REM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            mode_reg <= ITER_DIV;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                mode_reg <= cmd.mode;
                cnt_reg  <= (cmd.mode == ITER_SQRT) ? CW'(ROOT_W) : CW'(NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            if (cmd.mode == ITER_SQRT)
            begin
                src_reg <= SRC_W'(rad) << (SRC_W - RAD_W);
            end
            else
            begin
                src_reg <= SRC_W'(num) << (SRC_W - NUM_W);
            end
            rem_reg <= '0;
            res_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[REM_W-1:0] : rsh;
            res_reg <= {res_reg[SRC_W-2:0], ge};
            src_reg <= (mode_reg == ITER_SQRT) ? (src_reg << 2) : (src_reg << 1);
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quo       = res_reg[NUM_W-1:0];

endmodule
`default_nettype wire

/* hdl/point_gravity_integrator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_gravity_integrator
// One body under a point attractor, semi-implicit Euler step per tick, Q16.16.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid/in_ready    in_item_t  (frame_time, restart)
//  out       output     out_valid/out_ready  out_item_t (pos_x/y/z, saturated)
//  cfg       input      cfg_en, no wait      cfg_index, cfg_data
//
//  A restart tick goes straight to S_FIN to give its result. A stepping
//  tick passes through the shared divide/square-root unit: one root of
//  34 bits and five divisions. The input is ready again once the result
//  is written to the output register.
//  A tick with the body on the attractor skips the divisions and the pull.
//  Reset is asynchronous and active low and loads the register defaults.
//  The result sits in an output register, so a stalled output only holds the
//  block once the next result is ready to be written.
// ----------------------------------------------------------------------------
module point_gravity_integrator
    import pgi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire in_item_t             in_data,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      out_item_t            out_data,
    input  wire logic                 cfg_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int NUM_W = 32 + 2 * FRAC_BITS;
    localparam int T_W   = 32 + FRAC_BITS;
    localparam int DIR_W = FRAC_BITS + 1;

    typedef enum logic [4:0]
    {
        S_IDLE,
        S_DIFF,
        S_SQ,
        S_SQ_ACC,
        S_SQRT,
        S_SQRT_WAIT,
        S_DIV_T,
        S_DIV_T_WAIT,
        S_DIV_M,
        S_DIV_M_WAIT,
        S_DIR,
        S_DIR_WAIT,
        S_PMUL,
        S_PULL,
        S_AMUL,
        S_APOS,
        S_FIN
    } state_t;

    state_t              state_reg;
    logic [31:0]         cfg_reg [CFG_COUNT];
    logic [31:0]         pos_reg [3];
    logic [31:0]         vel_reg [3];
    logic [32:0]         d_reg   [3];
    logic [1:0]          idx_reg;
    logic [RAD_W-1:0]    sum_reg;
    logic [65:0]         mul_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [T_W-1:0]      t_reg;
    logic [31:0]         mag_reg;
    logic [DIR_W-1:0]    dir_reg;
    logic [15:0]         dt_reg;
    logic                flag_reg;
    logic [NUM_W-1:0]    num_reg;
    iter_cmd_t           cmd_reg;
    out_item_t           out_reg;
    logic                out_valid_reg;

    iter_stat_t          it_stat;
    logic [NUM_W-1:0]    it_quo;

    logic [32:0]         ad;
    logic [31:0]         av;
    logic [32:0]         mul_a;
    logic [32:0]         mul_b;
    logic [65:0]         prod;
    logic [31:0]         pmag;
    logic [33:0]         pull34;
    logic [31:0]         pull32;
    logic [33:0]         vsum;
    logic [31:0]         smag;
    logic [33:0]         psum;

    pgi_iter #(.NUM_W(NUM_W)) u_iter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_reg),
        .num   (num_reg),
        .rad   (sum_reg),
        .den   (dist_reg),
        .stat  (it_stat),
        .quo   (it_quo)
    );

    always_comb
    begin
        ad = d_reg[idx_reg][32] ? (~d_reg[idx_reg] + 33'd1) : d_reg[idx_reg];
        av = vel_reg[idx_reg][31] ? (~vel_reg[idx_reg] + 32'd1) : vel_reg[idx_reg];

        case (state_reg)
            S_SQ:
            begin
                mul_a = ad;
                mul_b = ad;
            end
            S_PMUL:
            begin
                mul_a = {1'b0, mag_reg};
                mul_b = 33'(dir_reg);
            end
            default:
            begin
                mul_a = {1'b0, av};
                mul_b = 33'(dt_reg);
            end
        endcase
        prod = mul_a * mul_b;

        // Pull on one axis: the sign follows the offset, then two saturations.
        pmag   = mul_reg[FRAC_BITS+31:FRAC_BITS];
        pull34 = d_reg[idx_reg][32] ? (34'd0 - {2'b00, pmag}) : {2'b00, pmag};
        pull32 = sat_val(pull34);
        vsum   = {{2{vel_reg[idx_reg][31]}}, vel_reg[idx_reg]}
               + {{2{pull32[31]}}, pull32};

        smag = mul_reg[TIME_BITS+31:TIME_BITS];
        psum = {{2{pos_reg[idx_reg][31]}}, pos_reg[idx_reg]}
             + (vel_reg[idx_reg][31] ? (34'd0 - {2'b00, smag}) : {2'b00, smag});
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg[0]    <= RST_ATTR_X;
            cfg_reg[1]    <= RST_ATTR_Y;
            cfg_reg[2]    <= RST_ATTR_Z;
            cfg_reg[3]    <= RST_STRENGTH;
            cfg_reg[4]    <= RST_START_VX;
            cfg_reg[5]    <= RST_START_VY;
            cfg_reg[6]    <= RST_START_VZ;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                d_reg[i]   <= '0;
            end
            vel_reg[0]    <= RST_START_VX;
            vel_reg[1]    <= RST_START_VY;
            vel_reg[2]    <= RST_START_VZ;
            idx_reg       <= '0;
            sum_reg       <= '0;
            mul_reg       <= '0;
            dist_reg      <= '0;
            t_reg         <= '0;
            mag_reg       <= '0;
            dir_reg       <= '0;
            dt_reg        <= '0;
            flag_reg      <= 1'b0;
            num_reg       <= '0;
            cmd_reg       <= '{start: 1'b0, mode: ITER_DIV};
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The unit is started for one cycle from each launching state.
            cmd_reg.start <= (state_reg == S_SQRT) || (state_reg == S_DIV_T)
                          || (state_reg == S_DIV_M) || (state_reg == S_DIR);

            if (cfg_en)
            begin
                unique case (cfg_index)
                    CFG_ATTR_X:   cfg_reg[0] <= cfg_data;
                    CFG_ATTR_Y:   cfg_reg[1] <= cfg_data;
                    CFG_ATTR_Z:   cfg_reg[2] <= cfg_data;
                    CFG_STRENGTH: cfg_reg[3] <= cfg_data;
                    CFG_START_VX: cfg_reg[4] <= cfg_data;
                    CFG_START_VY: cfg_reg[5] <= cfg_data;
                    CFG_START_VZ: cfg_reg[6] <= cfg_data;
                    default:      ;
                endcase
            end

            if ((state_reg == S_FIN) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        dt_reg   <= in_data.frame_time;
                        flag_reg <= 1'b0;
                        if (in_data.restart)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                pos_reg[i] <= '0;
                                vel_reg[i] <= cfg_reg[4+i];
                            end
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_DIFF;
                        end
                    end
                end
                S_DIFF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        d_reg[i] <= {cfg_reg[i][31], cfg_reg[i]}
                                  - {pos_reg[i][31], pos_reg[i]};
                    end
                    idx_reg   <= '0;
                    sum_reg   <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    mul_reg   <= prod;
                    state_reg <= S_SQ_ACC;
                end
                S_SQ_ACC:
                begin
                    sum_reg <= sum_reg + RAD_W'(mul_reg);
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_SQ;
                    end
                end
                S_SQRT:
                begin
                    cmd_reg.mode <= ITER_SQRT;
                    state_reg    <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT:
                begin
                    if (it_stat.done)
                    begin
                        dist_reg <= it_quo[DIST_W-1:0];
                        idx_reg  <= '0;
                        // On the attractor itself there is no pull at all.
                        state_reg <= (it_quo[DIST_W-1:0] == '0) ? S_AMUL : S_DIV_T;
                    end
                end
                S_DIV_T:
                begin
                    num_reg      <= NUM_W'(cfg_reg[3]) << FRAC_BITS;
                    cmd_reg.mode <= ITER_DIV;
                    state_reg    <= S_DIV_T_WAIT;
                end
                S_DIV_T_WAIT:
                begin
                    if (it_stat.done)
                    begin
                        t_reg     <= it_quo[T_W-1:0];
                        state_reg <= S_DIV_M;
                    end
                end
                S_DIV_M:
                begin
                    num_reg      <= NUM_W'(t_reg) << FRAC_BITS;
                    cmd_reg.mode <= ITER_DIV;
                    state_reg    <= S_DIV_M_WAIT;
                end
                S_DIV_M_WAIT:
                begin
                    if (it_stat.done)
                    begin
                        if (|it_quo[NUM_W-1:31])
                        begin
                            mag_reg  <= 32'h8000_0000;
                            flag_reg <= 1'b1;
                        end
                        else
                        begin
                            mag_reg <= {1'b0, it_quo[30:0]};
                        end
                        idx_reg   <= '0;
                        state_reg <= S_DIR;
                    end
                end
                S_DIR:
                begin
                    num_reg      <= NUM_W'(ad) << FRAC_BITS;
                    cmd_reg.mode <= ITER_DIV;
                    state_reg    <= S_DIR_WAIT;
                end
                S_DIR_WAIT:
                begin
                    if (it_stat.done)
                    begin
                        dir_reg   <= it_quo[DIR_W-1:0];
                        state_reg <= S_PMUL;
                    end
                end
                S_PMUL:
                begin
                    mul_reg   <= prod;
                    state_reg <= S_PULL;
                end
                S_PULL:
                begin
                    vel_reg[idx_reg] <= sat_val(vsum);
                    flag_reg <= flag_reg | sat_ovf(pull34) | sat_ovf(vsum);
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_AMUL;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_DIR;
                    end
                end
                S_AMUL:
                begin
                    mul_reg   <= prod;
                    state_reg <= S_APOS;
                end
                S_APOS:
                begin
                    pos_reg[idx_reg] <= sat_val(psum);
                    flag_reg <= flag_reg | sat_ovf(psum);
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_AMUL;
                    end
                end
                S_FIN:
                begin
                    // Wait for the output register to be free before the transfer.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.pos_x     <= pos_reg[0];
                        out_reg.pos_y     <= pos_reg[1];
                        out_reg.pos_z     <= pos_reg[2];
                        out_reg.saturated <= flag_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        it_stat.done |-> (state_reg == S_SQRT_WAIT || state_reg == S_DIV_T_WAIT ||
                          state_reg == S_DIV_M_WAIT || state_reg == S_DIR_WAIT))
        else $error("iterative unit finished outside a wait state");

    a_no_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_T || state_reg == S_DIV_M || state_reg == S_DIR)
        |-> (dist_reg != '0))
        else $error("division started with zero distance");

    a_pull_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PMUL) |->
        ((mag_reg <= 32'h8000_0000) && (dir_reg <= (DIR_W'(1) << FRAC_BITS))))
        else $error("pull magnitude or direction out of range");

    a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.restart) |=>
        ((pos_reg[0] == '0) && (pos_reg[1] == '0) && (pos_reg[2] == '0) && !flag_reg))
        else $error("restart did not reload the origin");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point gravity integrator. Ticks are queued by
// the stimulus block, driven by a clocked driver and predicted as they are
// accepted; a clocked monitor compares every result with the oldest
// prediction. The attractor, strength and start velocity are changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import pgi_pkg::*;

    localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_NEG = 32'h8000_0000;
    localparam longint unsigned MAG_CAP = 64'd1 << 31;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    in_item_t  tick_q[$];
    out_item_t expected_pos_q[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        mismatches;

    // Bench copy of the registers and of the body state.
    logic [31:0] regs[CFG_COUNT];
    longint      body_pos[3];
    longint      body_vel[3];
    bit          clipped;

    point_gravity_integrator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint clip32(longint x);
        longint r;
        r = x;
        if (x > 64'sd2147483647)
        begin
            clipped = 1'b1;
            r = 64'sd2147483647;
        end
        else if (x < -64'sd2147483648)
        begin
            clipped = 1'b1;
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic longint as_signed(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [34:0] wide_root(logic [71:0] s);
        logic [34:0] r;
        logic [34:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--)
        begin
            c = r | (35'd1 << b);
            if ({37'd0, c} * {37'd0, c} <= s)
            begin
                r = c;
            end
        end
        return r;
    endfunction

    // One Euler step (or a restart) of the body; returns the position result.
    function automatic out_item_t step_body(in_item_t tick);
        longint            d[3];
        longint unsigned   m;
        longint unsigned   dist_len;
        longint unsigned   t;
        longint unsigned   q;
        longint unsigned   rem;
        longint unsigned   mag;
        longint unsigned   dir;
        longint            p;
        longint            s;
        logic [71:0]       sq_sum;
        out_item_t         res;
        clipped = 1'b0;
        if (tick.restart)
        begin
            for (int i = 0; i < 3; i++)
            begin
                body_pos[i] = 0;
                body_vel[i] = as_signed(regs[CFG_START_VX + i]);
            end
        end
        else
        begin
            sq_sum = '0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = as_signed(regs[CFG_ATTR_X + i]) - body_pos[i];
                m = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
                sq_sum += {8'd0, m} * {8'd0, m};
            end
            dist_len = {29'd0, wide_root(sq_sum)};
            // On the attractor itself the pull is zero and the velocity kept.
            if (dist_len != 0)
            begin
                t = {16'd0, regs[CFG_STRENGTH], 16'd0} / dist_len;
                q = t / dist_len;
                rem = t % dist_len;
                if (q >= (64'd1 << 15))
                begin
                    mag = MAG_CAP;
                    clipped = 1'b1;
                end
                else
                begin
                    mag = (q << 16) + ((rem << 16) / dist_len);
                    if (mag > MAG_CAP)
                    begin
                        mag = MAG_CAP;
                        clipped = 1'b1;
                    end
                end
                for (int i = 0; i < 3; i++)
                begin
                    m = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
                    dir = (m << 16) / dist_len;
                    p = longint'((mag * dir) >> 16);
                    p = clip32((d[i] < 0) ? -p : p);
                    body_vel[i] = clip32(body_vel[i] + p);
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                m = (body_vel[i] < 0) ? longint'(-body_vel[i]) : longint'(body_vel[i]);
                s = longint'((m * {48'd0, tick.frame_time}) >> TIME_BITS);
                body_pos[i] = clip32(body_pos[i] + ((body_vel[i] < 0) ? -s : s));
            end
        end
        res.pos_x = body_pos[0][31:0];
        res.pos_y = body_pos[1][31:0];
        res.pos_z = body_pos[2][31:0];
        res.saturated = clipped;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t ns: %s got %h, expected %h", $time, what, got, want);
    endtask

    // Driver: a new tick is offered only once the previous one has transferred.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_pos_q.push_back(step_body(in_data));
            end
            if (!in_valid || in_ready)
            begin
                if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= tick_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the output at random and checks each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pos_q.size() == 0)
                begin
                    report_mismatch("unexpected result", out_data.pos_x, '0);
                end
                else
                begin
                    want = expected_pos_q.pop_front();
                    if (out_data.pos_x !== want.pos_x)
                    begin
                        report_mismatch("pos_x", out_data.pos_x, want.pos_x);
                    end
                    if (out_data.pos_y !== want.pos_y)
                    begin
                        report_mismatch("pos_y", out_data.pos_y, want.pos_y);
                    end
                    if (out_data.pos_z !== want.pos_z)
                    begin
                        report_mismatch("pos_z", out_data.pos_z, want.pos_z);
                    end
                    if (out_data.saturated !== want.saturated)
                    begin
                        report_mismatch("saturated", 32'(out_data.saturated),
                                        32'(want.saturated));
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_idle();
        while (tick_q.size() > 0 || expected_pos_q.size() > 0 || in_valid)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic load_regs(logic [31:0] vals[CFG_COUNT]);
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            @(posedge clk);
            cfg_en    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            regs[i] = vals[i];
        end
        @(posedge clk);
        cfg_en <= 1'b0;
    endtask

    task automatic push_tick(logic [15:0] dt, logic rs);
        in_item_t it;
        it.frame_time = dt;
        it.restart    = rs;
        tick_q.push_back(it);
    endtask

    function automatic logic [31:0] pick_value(bit is_signed);
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = $urandom();
            1: v = is_signed ? MAX_POS : 32'hFFFF_FFFF;
            2: v = is_signed ? MIN_NEG : 32'd0;
            3: v = $urandom_range(32'h0040_0000);
            4: v = is_signed ? -$urandom_range(32'h0040_0000) : $urandom_range(32'h0400_0000);
            default: v = $urandom_range(32'h0001_0000);
        endcase
        return v;
    endfunction

    initial
    begin
        logic [31:0] vals[CFG_COUNT];
        rst_n     = 1'b0;
        cfg_en    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        mismatches = 0;
        send_idle_pct = 34;
        recv_idle_pct = 78;
        regs = '{RST_ATTR_X, RST_ATTR_Y, RST_ATTR_Z, RST_STRENGTH,
                 RST_START_VX, RST_START_VY, RST_START_VZ};
        body_pos = '{0, 0, 0};
        body_vel = '{0, 13107, 45875};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, frame time extremes and restarts.
        push_tick(16'd0, 1'b0);
        push_tick(16'hFFFF, 1'b0);
        push_tick(16'd1, 1'b0);
        push_tick(16'h8000, 1'b0);
        push_tick(16'hFFFF, 1'b1);
        push_tick(16'hFFFF, 1'b0);
        push_tick(16'h5555, 1'b0);
        push_tick(16'hAAAA, 1'b0);
        wait_idle();

        // Attractor at the origin: after a restart the body sits on it.
        vals = '{32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd65536, MIN_NEG, 32'd1};
        load_regs(vals);
        push_tick(16'h1234, 1'b1);
        push_tick(16'hFFFF, 1'b0);
        push_tick(16'hFFFF, 1'b0);
        push_tick(16'hFFFF, 1'b0);
        wait_idle();

        // Extremes: far attractor, huge strength and start velocities.
        vals = '{MAX_POS, MIN_NEG, MAX_POS, 32'hFFFF_FFFF, MAX_POS, MIN_NEG, MIN_NEG};
        load_regs(vals);
        push_tick(16'hFFFF, 1'b1);
        for (int i = 0; i < 4; i++)
        begin
            push_tick(16'hFFFF, 1'b0);
        end
        push_tick(16'd0, 1'b1);
        vals = '{32'd1, MIN_NEG, 32'd0, 32'd0, MIN_NEG, MAX_POS, 32'd0};
        wait_idle();
        load_regs(vals);
        push_tick(16'd7, 1'b0);
        push_tick(16'hFFFF, 1'b1);
        push_tick(16'hFFFF, 1'b0);
        wait_idle();

        // Random phases: restart, then a run of steps with random frame times and occasional restarts.
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 34;
            end
            else if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                vals[i] = pick_value(i != CFG_STRENGTH);
            end
            load_regs(vals);
            push_tick(16'($urandom()), 1'b1);
            for (int n = 0; n < 110; n++)
            begin
                if ($urandom_range(19) == 0)
                begin
                    push_tick(16'($urandom()), 1'b1);
                end
                else if ($urandom_range(3) == 0)
                begin
                    push_tick(16'($urandom_range(255)), 1'b0);
                end
                else
                begin
                    push_tick(16'($urandom()), 1'b0);
                end
            end
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("point_gravity_integrator verification clean");
        end
        else
        begin
            $display("point_gravity_integrator verification failed");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("point_gravity_integrator verification failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/pgi_pkg.sv
hdl/pgi_iter.sv
hdl/point_gravity_integrator.sv
tb/sv/tb_top.sv
